// File: src/ssb_pkg.sv
// Shared types, codes and segment tables for the seven-segment scan driver.
package ssb_pkg;

  localparam int ACCUM_WIDTH_DEF = 16;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 16;
  localparam int SEG_W           = 7;
  localparam int NUM_DIGITS      = 4;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_DIGITS = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_LOCKED = 2'd3
  } mode_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_STEP     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DARK_THRESHOLD = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_DIGIT   = 8'd2;

  localparam logic [15:0] BLINK_STEP_RST     = 16'd1;
  localparam logic [15:0] DARK_THRESHOLD_RST = 16'd32768;

  typedef logic [SEG_W-1:0] seg_t;

  typedef struct packed {
    mode_t      mode;
    logic [3:0] digit_zero;
    logic [3:0] digit_one;
    logic [3:0] digit_two;
    logic [3:0] digit_three;
  } in_item_t;

  typedef struct packed {
    seg_t       segments;
    logic [1:0] digit_select;
    logic       blanked;
  } out_item_t;

  // The words "OPEn" and "LChd", position 0 first.
  localparam seg_t SEG_OPEN   [NUM_DIGITS] = '{7'h3F, 7'h73, 7'h79, 7'h54};
  localparam seg_t SEG_LOCKED [NUM_DIGITS] = '{7'h38, 7'h39, 7'h74, 7'h5E};

  // Decimal digit to segment pattern; codes above nine show blank.
  function automatic seg_t decode_digit(input logic [3:0] code);
    seg_t pat;
    unique case (code)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

// File: src/seven_segment_scan_with_blink.sv
// Four-digit multiplexed seven-segment scan driver with one blinking digit.
//
// Input channel (in_valid / in_stall / in_data): each item is either a load
// (digits, "OPEn" or "LChd") that rewrites the four-entry segment store, or a
// tick that produces one result item for the current scan position.
// Result channel (out_valid / out_stall / out_data): segments, the select
// code of the position and a flag saying the position was blanked by blinking.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes
// blink_step, the dark threshold and active_digit; cfg_ready is always high
// and writes to unknown indexes are dropped.
// A tick's result is registered and offered from the cycle after acceptance.
// Throughput: one item per cycle while the receiver does not stall; the
// single output register sets this, as the accumulator add, compare and store
// read all fit between the input handshake and that register. Loads never
// produce a result. Reset clears the store (blank display), the scan position
// and the accumulator, and loads the register defaults. While the receiver
// stalls with a result waiting, in_stall is raised and the result holds.
module seven_segment_scan_with_blink #(
  parameter int ACCUM_WIDTH = ssb_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ssb_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ssb_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ssb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ssb_pkg::*;

  localparam int CMP_W = (ACCUM_WIDTH > 16) ? ACCUM_WIDTH : 16;

  logic [15:0]            blink_step_r;
  logic [15:0]            dark_threshold_r;
  logic [1:0]             active_digit_r;
  seg_t                   store_r [NUM_DIGITS];
  logic [1:0]             pos_r;
  logic [ACCUM_WIDTH-1:0] acc_r;
  logic [ACCUM_WIDTH-1:0] acc_nxt;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  out_item_t              out_data_nxt;
  logic                   in_fire;
  logic                   tick_fire;
  logic                   blank;
  logic [CMP_W-1:0]       acc_ext;
  logic [CMP_W-1:0]       limit_ext;
  logic [CMP_W-1:0]       step_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_fire   = in_valid & ~in_stall;
  assign tick_fire = in_fire & (in_data.mode == MODE_TICK);

  // The step is truncated when the accumulator is narrower than it.
  assign step_ext  = CMP_W'(blink_step_r);
  assign acc_nxt   = acc_r + step_ext[ACCUM_WIDTH-1:0];
  assign acc_ext   = CMP_W'(acc_nxt);
  assign limit_ext = CMP_W'(dark_threshold_r);
  assign blank     = (acc_ext > limit_ext) && (pos_r == active_digit_r);

  always_comb begin
    out_data_nxt.segments     = blank ? '0 : store_r[pos_r];
    out_data_nxt.digit_select = pos_r;
    out_data_nxt.blanked      = blank;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_step_r     <= BLINK_STEP_RST;
      dark_threshold_r <= DARK_THRESHOLD_RST;
      active_digit_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BLINK_STEP: begin
          blink_step_r <= cfg_data[15:0];
        end
        CFG_DARK_THRESHOLD: begin
          dark_threshold_r <= cfg_data[15:0];
        end
        CFG_ACTIVE_DIGIT: begin
          active_digit_r <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        store_r[i] <= '0;
      end
    end else if (in_fire) begin
      unique case (in_data.mode)
        MODE_DIGITS: begin
          store_r[0] <= decode_digit(in_data.digit_zero);
          store_r[1] <= decode_digit(in_data.digit_one);
          store_r[2] <= decode_digit(in_data.digit_two);
          store_r[3] <= decode_digit(in_data.digit_three);
        end
        MODE_OPEN: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            store_r[i] <= SEG_OPEN[i];
          end
        end
        MODE_LOCKED: begin
          for (int i = 0; i < NUM_DIGITS; i++) begin
            store_r[i] <= SEG_LOCKED[i];
          end
        end
        MODE_TICK: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
    end else if (tick_fire) begin
      pos_r <= pos_r + 2'd1;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tick_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: src/ssb_checker.sv
// Port-level checker for the seven-segment scan driver, with its bind.
module ssb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input ssb_pkg::in_item_t    in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input ssb_pkg::out_item_t   out_data
);
  import ssb_pkg::*;

  // A waiting result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // A blanked position drives every segment off.
  a_blank_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.blanked |-> out_data.segments == '0)
    else $error("blanked item has segments lit");

  // Input is held back only while a result waits on a stalled receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // Every accepted tick is followed by a result item.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.mode == MODE_TICK) |=> out_valid)
    else $error("tick item gave no result");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind seven_segment_scan_with_blink ssb_checker u_ssb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
